// File: hdl/mcdr_pkg.sv
// ----------------------------------------------------------------------------
// mcdr_pkg
// Types and constants shared by the multi-channel dimmer ramp block.
// ----------------------------------------------------------------------------
package mcdr_pkg;

  localparam int CMD_W     = 3;
  localparam int CHAN_W    = 2;
  localparam int VALUE_W   = 16;
  localparam int LEVEL_W   = 10;
  localparam int MS_W      = 25;
  localparam int STEPS_W   = 11;
  localparam int UNITS_W   = 11;
  localparam int SECS_W    = 15;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 10'd1023;
  localparam logic [STEPS_W-1:0] STEPS_MAX   = 11'd2047;
  localparam logic [UNITS_W-1:0] LEVEL_SPAN  = 11'd1024;
  localparam logic [9:0]         MS_PER_SEC  = 10'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_SET_ON  = 3'd1,
    CMD_SET_DIM = 3'd2,
    CMD_SUNSET  = 3'd3,
    CMD_SUNRISE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV_GO,
    ST_DIV,
    ST_WRITE
  } state_t;

  // One channel's state as held in the state memory
  typedef struct packed {
    logic               relay;
    logic [LEVEL_W-1:0] level;
    logic               ramp_up;
    logic               ramp_down;
    logic [LEVEL_W-1:0] origin;
    logic [MS_W-1:0]    per_step;
    logic [MS_W-1:0]    in_step;
    logic [STEPS_W-1:0] steps;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    relay:     1'b1,
    level:     '0,
    ramp_up:   1'b0,
    ramp_down: 1'b0,
    origin:    '0,
    per_step:  25'd1,
    in_step:   '0,
    steps:     '0
  };

endpackage

// File: hdl/mcdr_if.sv
// ----------------------------------------------------------------------------
// mcdr_in_if / mcdr_out_if
// Valid/ready channels for command words and status report words.
// ----------------------------------------------------------------------------
interface mcdr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mcdr_pkg::CMD_W-1:0]           command;
  logic [mcdr_pkg::CHAN_W-1:0]          channel;
  logic signed [mcdr_pkg::VALUE_W-1:0]  value;

  modport source (output valid, command, channel, value, input ready);
  modport sink   (input valid, command, channel, value, output ready);
endinterface

interface mcdr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mcdr_pkg::CHAN_W-1:0]          report_channel;
  logic                                 relay_on;
  logic [mcdr_pkg::LEVEL_W-1:0]         dim_level;
  logic                                 is_sunsetting;
  logic                                 is_sunrising;
  logic                                 last_report;

  modport source (output valid, report_channel, relay_on, dim_level, is_sunsetting,
                  is_sunrising, last_report, input ready);
  modport sink   (input valid, report_channel, relay_on, dim_level, is_sunsetting,
                  is_sunrising, last_report, output ready);
endinterface

// File: hdl/mcdr_state_mem.sv
// ----------------------------------------------------------------------------
// mcdr_state_mem
// Per-channel state memory: one write port, one registered read port.
// Entries never written read back as the reset state.
// ----------------------------------------------------------------------------
module mcdr_state_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output mcdr_pkg::chan_state_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  mcdr_pkg::chan_state_t wr_data
);
  import mcdr_pkg::*;

  chan_state_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  chan_state_t rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : CHAN_RESET;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/mcdr_div.sv
// ----------------------------------------------------------------------------
// mcdr_div
// Restoring divider, one quotient bit per cycle: ramp length in ms divided
// by the level span (1024) minus the channel's present level.
// ----------------------------------------------------------------------------
module mcdr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mcdr_pkg::MS_W-1:0]    dividend,
  input  logic [mcdr_pkg::UNITS_W-1:0] divisor,
  output logic [mcdr_pkg::MS_W-1:0]    quotient,
  output logic                         done
);
  import mcdr_pkg::*;

  localparam int CNT_W = $clog2(MS_W + 1);

  logic [MS_W-1:0]    quo_r,  quo_nxt;
  logic [UNITS_W-1:0] rem_r,  rem_nxt;
  logic [UNITS_W-1:0] dsr_r;
  logic [CNT_W-1:0]   cnt_r,  cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [UNITS_W:0]   trial;
  logic               fits;

  always_comb begin
    trial    = {rem_r, quo_r[MS_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(MS_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? UNITS_W'(trial - {1'b0, dsr_r}) : trial[UNITS_W-1:0];
      quo_nxt = {quo_r[MS_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: hdl/multi_channel_dimmer_ramp.sv
// ----------------------------------------------------------------------------
// multi_channel_dimmer_ramp
// Relay and inverted dim level per channel, with timed sunset and sunrise
// ramps driven by one-millisecond tick words.
// ----------------------------------------------------------------------------
// Each command word is handled alone. Channel state sits in a small memory
// with a registered read; every channel visit is a read state followed by an
// update-and-report state. A tick visits the channels in turn and returns
// CHANNELS report words; set_on, set_dim and an ignored sunset visit one
// channel and return one report word; a sunset or sunrise start also waits on
// the 25-step serial divider that works out the milliseconds per level step.
// Commands with an unknown code or a channel out of range are dropped
// without a report. Report words wait in an output register, so a stall on
// the report side only holds the block when a further word must be sent.
// ----------------------------------------------------------------------------
module multi_channel_dimmer_ramp #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  mcdr_in_if.sink     in_chan,
  mcdr_out_if.source  out_chan
);
  import mcdr_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [MS_W-1:0]      ms_r;

  logic                 in_fire;
  logic                 cmd_known;
  logic                 is_tick;
  logic                 ramp_start;
  logic                 last_idx;
  logic                 out_free;

  logic                 mem_rd_en;
  logic                 mem_wr_en;
  chan_state_t          ent;
  chan_state_t          tick_ent;
  chan_state_t          cmd_ent;
  chan_state_t          ramp_ent;
  chan_state_t          upd_ent;
  logic                 emit;

  logic                 div_start;
  logic [MS_W-1:0]      div_quo;
  logic                 div_done;
  logic [UNITS_W-1:0]   units;

  logic [MS_W:0]        in_inc;
  logic                 step_end;
  logic [STEPS_W-1:0]   steps_adv;
  logic [STEPS_W:0]     sum_up;
  logic [STEPS_W-1:0]   v_dn;

  logic                 out_valid_r;
  logic [CHAN_W-1:0]    out_chan_r;
  logic                 out_relay_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 out_up_r;
  logic                 out_down_r;
  logic                 out_last_r;

  mcdr_state_mem #(
    .DEPTH (CHANNELS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (ent),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_r),
    .wr_data (upd_ent)
  );

  mcdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ms_r),
    .divisor  (units),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign cmd_known     = (in_chan.command == CMD_TICK) ||
                         ((in_chan.command == CMD_SET_ON || in_chan.command == CMD_SET_DIM ||
                           in_chan.command == CMD_SUNSET || in_chan.command == CMD_SUNRISE) &&
                          (int'(in_chan.channel) < CHANNELS));
  assign is_tick       = (cmd_r == CMD_TICK);
  assign ramp_start    = (cmd_r == CMD_SUNRISE) || (cmd_r == CMD_SUNSET && ent.relay);
  assign last_idx      = (idx_r == IDX_W'(CHANNELS - 1));
  assign out_free      = !out_valid_r || out_chan.ready;
  assign units         = LEVEL_SPAN - {1'b0, ent.level};

  // Tick update for one channel
  always_comb begin
    in_inc    = {1'b0, ent.in_step} + 1'b1;
    step_end  = in_inc >= {1'b0, ent.per_step};
    steps_adv = ent.steps;
    if (step_end && ent.steps != STEPS_MAX) begin
      steps_adv = ent.steps + 1'b1;
    end
    sum_up = {2'b00, ent.origin} + {1'b0, steps_adv};
    if (steps_adv >= LEVEL_SPAN) begin
      v_dn = '0;
    end else begin
      v_dn = LEVEL_SPAN - steps_adv;
    end
    if (v_dn > {1'b0, LEVEL_MAX}) begin
      v_dn = {1'b0, LEVEL_MAX};
    end
    if (v_dn < {1'b0, ent.origin}) begin
      v_dn = {1'b0, ent.origin};
    end

    tick_ent = ent;
    if (ent.ramp_up) begin
      if (ent.level == LEVEL_MAX) begin
        tick_ent.ramp_up = 1'b0;
        tick_ent.relay   = 1'b0;
      end else begin
        tick_ent.in_step = step_end ? '0 : in_inc[MS_W-1:0];
        tick_ent.steps   = steps_adv;
        tick_ent.level   = (sum_up > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : sum_up[LEVEL_W-1:0];
      end
    end else if (ent.ramp_down) begin
      if (ent.origin == ent.level) begin
        tick_ent.ramp_down = 1'b0;
      end else begin
        tick_ent.in_step = step_end ? '0 : in_inc[MS_W-1:0];
        tick_ent.steps   = steps_adv;
        tick_ent.level   = v_dn[LEVEL_W-1:0];
      end
    end
  end

  // Manual commands; an ignored sunset leaves the entry as it is
  always_comb begin
    cmd_ent = ent;
    case (cmd_r)
      CMD_SET_ON: begin
        cmd_ent.ramp_up   = 1'b0;
        cmd_ent.ramp_down = 1'b0;
        if (val_r == 16'sd1) begin
          cmd_ent.relay = 1'b1;
        end else if (val_r == 16'sd0) begin
          cmd_ent.relay = 1'b0;
        end
      end
      CMD_SET_DIM: begin
        cmd_ent.ramp_up   = 1'b0;
        cmd_ent.ramp_down = 1'b0;
        if (val_r[VALUE_W-1]) begin
          cmd_ent.level = '0;
        end else if (val_r > $signed({6'd0, LEVEL_MAX})) begin
          cmd_ent.level = LEVEL_MAX;
        end else begin
          cmd_ent.level = val_r[LEVEL_W-1:0];
        end
      end
      default: begin
        cmd_ent = ent;
      end
    endcase
  end

  // Ramp start once the step interval is known
  always_comb begin
    ramp_ent          = ent;
    ramp_ent.per_step = (div_quo == '0) ? MS_W'(1) : div_quo;
    ramp_ent.in_step  = '0;
    ramp_ent.steps    = '0;
    ramp_ent.origin   = ent.level;
    if (cmd_r == CMD_SUNRISE) begin
      ramp_ent.ramp_up   = 1'b0;
      ramp_ent.ramp_down = 1'b1;
      ramp_ent.relay     = 1'b1;
      ramp_ent.level     = LEVEL_MAX;
    end else begin
      ramp_ent.ramp_up   = 1'b1;
      ramp_ent.ramp_down = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && cmd_known) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!is_tick && ramp_start) begin
          state_nxt = ST_DIV_GO;
        end else if (out_free) begin
          state_nxt = (is_tick && !last_idx) ? ST_READ : ST_IDLE;
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_rd_en = 1'b0;
    emit      = 1'b0;
    div_start = 1'b0;
    upd_ent   = cmd_ent;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = (in_chan.command == CMD_TICK) ? '0 : IDX_W'(in_chan.channel);
        end
      end
      ST_READ: begin
        mem_rd_en = 1'b1;
      end
      ST_EXEC: begin
        upd_ent = is_tick ? tick_ent : cmd_ent;
        if (is_tick || !ramp_start) begin
          emit = out_free;
          if (out_free && is_tick && !last_idx) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_WRITE: begin
        upd_ent = ramp_ent;
        emit    = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign mem_wr_en = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_chan.command;
      val_r <= in_chan.value;
    end
    // Negative durations count as zero
    if (state_r == ST_EXEC) begin
      ms_r <= val_r[VALUE_W-1] ? '0 :
              MS_W'({10'd0, val_r[SECS_W-1:0]} * {15'd0, MS_PER_SEC});
    end
    if (emit) begin
      out_chan_r  <= CHAN_W'(idx_r);
      out_relay_r <= upd_ent.relay;
      out_level_r <= upd_ent.level;
      out_up_r    <= upd_ent.ramp_up;
      out_down_r  <= upd_ent.ramp_down;
      out_last_r  <= !is_tick || last_idx;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.report_channel = out_chan_r;
  assign out_chan.relay_on       = out_relay_r;
  assign out_chan.dim_level      = out_level_r;
  assign out_chan.is_sunsetting  = out_up_r;
  assign out_chan.is_sunrising   = out_down_r;
  assign out_chan.last_report    = out_last_r;

endmodule
